// File: rtl/stdc_pkg.sv
// Shared types and constants for the settable time-of-day clock.
`timescale 1ns / 1ps

package stdc_pkg;

    localparam int HOUR_W = 16;
    localparam int MIN_W  = 16;
    localparam int SEC_W  = 6;
    localparam int KEY_W  = 4;
    localparam int VIEW_W = 2;

    localparam logic [SEC_W-1:0]  SEC_WRAP   = SEC_W'(60);
    localparam logic [MIN_W-1:0]  MIN_WRAP   = MIN_W'(60);
    localparam logic [HOUR_W-1:0] HOUR_WRAP  = HOUR_W'(24);

    localparam logic [HOUR_W-1:0] HOUR_RESET = HOUR_W'(1);
    localparam logic [MIN_W-1:0]  MIN_RESET  = MIN_W'(12);
    localparam logic [SEC_W-1:0]  SEC_RESET  = '0;

    localparam logic [KEY_W-1:0] KEY_ZERO = KEY_W'(0);
    localparam logic [KEY_W-1:0] KEY_ONE  = KEY_W'(1);
    localparam logic [KEY_W-1:0] KEY_TWO  = KEY_W'(2);
    localparam logic [KEY_W-1:0] KEY_NINE = KEY_W'(9);
    localparam logic [KEY_W-1:0] KEY_HASH = KEY_W'(11);

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_KEY  = 1'b1
    } t_op;

    typedef enum logic [VIEW_W-1:0] {
        VIEW_DISPLAY = 2'd0,
        VIEW_HOURS   = 2'd1,
        VIEW_MINUTES = 2'd2
    } t_view;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key_code;
    } t_item;

endpackage

// File: rtl/stdc_in_if.sv
// Input channel: tick or key beats.
`timescale 1ns / 1ps

interface stdc_in_if import stdc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output op, output key_code, input ready);
    modport sink   (input valid, input op, input key_code, output ready);
endinterface

// File: rtl/stdc_out_if.sv
// Output channel: time and edit status beats.
`timescale 1ns / 1ps

interface stdc_out_if import stdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic [VIEW_W-1:0] view;
    logic              editing;
    logic              digit_seen;

    modport source (output valid, output hours, output minutes, output seconds,
                    output view, output editing, output digit_seen, input ready);
    modport sink   (input valid, input hours, input minutes, input seconds,
                    input view, input editing, input digit_seen, output ready);
endinterface

// File: rtl/stdc_in_reg.sv
// Input register stage for tick and key beats.
`timescale 1ns / 1ps

module stdc_in_reg import stdc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    stdc_in_if.sink i_in,
    input  logic   i_adv,
    output logic   o_valid,
    output t_item  o_item
);

    logic  r_valid;
    t_item r_item;

    assign i_in.ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.op       <= t_op'(i_in.op);
            r_item.key_code <= i_in.key_code;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/stdc_core.sv
// Time and edit state update with the result register.
`timescale 1ns / 1ps

module stdc_core import stdc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_item     i_item,
    output logic      o_adv,
    stdc_out_if.source o_out
);

    logic [HOUR_W-1:0] r_hour,   n_hour;
    logic [MIN_W-1:0]  r_minute, n_minute;
    logic [SEC_W-1:0]  r_second, n_second;
    t_view             r_view,   n_view;
    logic              r_edit,   n_edit;
    logic              r_digit,  n_digit;
    logic              r_out_valid;

    logic [SEC_W-1:0]  sec_inc;
    logic [MIN_W-1:0]  min_tmp;
    logic [HOUR_W-1:0] hour_tmp;
    logic [HOUR_W-1:0] hour_ent;
    logic [MIN_W-1:0]  min_ent;
    logic [HOUR_W-1:0] digit_ext;
    logic              is_digit;

    assign o_adv = i_valid && (!r_out_valid || o_out.ready);

    assign digit_ext = HOUR_W'(i_item.key_code);
    assign is_digit  = i_item.key_code inside {[KEY_ZERO:KEY_NINE]};
    assign hour_ent  = r_digit ? (r_hour << 3) + (r_hour << 1) + digit_ext : digit_ext;
    assign min_ent   = r_digit ? (r_minute << 3) + (r_minute << 1) + MIN_W'(i_item.key_code)
                               : MIN_W'(i_item.key_code);

    always_comb begin
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_view   = r_view;
        n_edit   = r_edit;
        n_digit  = r_digit;
        sec_inc  = r_second + SEC_W'(1);
        min_tmp  = r_minute;
        hour_tmp = r_hour;
        if (i_item.op == OP_TICK) begin
            if (sec_inc >= SEC_WRAP) begin
                n_second = '0;
                min_tmp  = r_minute + MIN_W'(1);
            end else begin
                n_second = sec_inc;
            end
            if (min_tmp >= MIN_WRAP) begin
                n_minute = '0;
                hour_tmp = r_hour + HOUR_W'(1);
            end else begin
                n_minute = min_tmp;
            end
            if (hour_tmp >= HOUR_WRAP) begin
                n_hour = '0;
            end else begin
                n_hour = hour_tmp;
            end
        end else if (r_edit) begin
            if (is_digit) begin
                case (r_view)
                    VIEW_HOURS:   n_hour   = hour_ent;
                    VIEW_MINUTES: n_minute = min_ent;
                    default:      ;
                endcase
                n_digit = 1'b1;
            end else if (i_item.key_code == KEY_HASH) begin
                n_digit = 1'b0;
                n_edit  = 1'b0;
                n_view  = VIEW_DISPLAY;
            end
        end else begin
            case (i_item.key_code)
                KEY_ONE: begin
                    n_edit = 1'b1;
                    n_view = VIEW_HOURS;
                end
                KEY_TWO: begin
                    n_edit = 1'b1;
                    n_view = VIEW_MINUTES;
                end
                KEY_HASH: begin
                    n_view = VIEW_DISPLAY;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour      <= HOUR_RESET;
            r_minute    <= MIN_RESET;
            r_second    <= SEC_RESET;
            r_view      <= VIEW_DISPLAY;
            r_edit      <= 1'b0;
            r_digit     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_hour   <= n_hour;
                r_minute <= n_minute;
                r_second <= n_second;
                r_view   <= n_view;
                r_edit   <= n_edit;
                r_digit  <= n_digit;
            end
            if (o_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            o_out.hours      <= n_hour;
            o_out.minutes    <= n_minute;
            o_out.seconds    <= n_second;
            o_out.view       <= VIEW_W'(n_view);
            o_out.editing    <= n_edit;
            o_out.digit_seen <= n_digit;
        end
    end

    assign o_out.valid = r_out_valid;

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second < SEC_WRAP)
        else $error("seconds out of range");

    a_edit_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edit |-> (r_view != VIEW_DISPLAY))
        else $error("editing with display view");

    a_digit_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_edit |-> !r_digit)
        else $error("digit flag set outside editing");

    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && i_item.op == OP_TICK && r_second != SEC_W'(59))
        |=> (r_second == $past(r_second) + SEC_W'(1)))
        else $error("tick did not advance seconds");

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_out.seconds == r_second && o_out.editing == r_edit))
        else $error("result beat disagrees with state");

endmodule

// File: rtl/settable_time_of_day_clock.sv
// Top level of the settable time-of-day clock.
//
//   port     dir   beat contents
//   i_in     in    op (tick or key), key_code
//   o_out    out   hours, minutes, seconds, view, editing, digit_seen
//
// One beat in, one beat out; a beat passes through the input register and then the result register.
// A new beat is taken every cycle while the result side keeps up.
// The input register and the result register decouple the two sides.
// Synchronous reset: time 01:12:00, display view, no edit in progress.
// A stalled result holds the state update stage; the input register holds one more beat.
`timescale 1ns / 1ps

module settable_time_of_day_clock import stdc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stdc_in_if.sink    i_in,
    stdc_out_if.source o_out
);

    logic  in_valid;
    t_item in_item;
    logic  adv;

    stdc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    stdc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_item  (in_item),
        .o_adv   (adv),
        .o_out   (o_out)
    );

endmodule
